/* hw/rtl/ou8_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ou8_pkg
// Shared types, codes and constants for the oversampled 8N1 UART.
// ----------------------------------------------------------------------------
package ou8_pkg;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_DATA  = 2'd2,
        PH_STOP  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_QUEUE = 2'd1,
        ACT_TAKE  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    localparam int CFG_W   = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPB = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_THR = 1'b1;

    localparam logic [CFG_W-1:0] SPB_RESET = 6'd8;
    localparam logic [CFG_W-1:0] THR_RESET = 6'd4;
    localparam logic [CFG_W-1:0] SPB_MIN   = 6'd4;
    localparam logic [CFG_W-1:0] SPB_MAX   = 6'd32;

    localparam logic [5:0] LEVEL_MAX   = 6'd63;
    localparam logic [3:0] RX_BITS     = 4'd8;
    localparam logic [2:0] TX_LAST_BIT = 3'd7;

    // per-word strobes from the host pipeline, already qualified by advance
    typedef struct packed {
        logic tick;
        logic queue;
        logic take;
    } ou8_ctl_t;

    function automatic logic [CFG_W-1:0] clamp_spb(input logic [CFG_W-1:0] s);
        logic [CFG_W-1:0] r;
        r = s;
        if (s < SPB_MIN)
        begin
            r = SPB_MIN;
        end
        else if (s > SPB_MAX)
        begin
            r = SPB_MAX;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/oversampled_uart_8n1.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oversampled_uart_8n1
// 8N1 UART transceiver advanced one sample tick per tick-action input word.
//
// Input words carry an action: a sample tick (with the rx pin level), a
// transmit byte to queue, or a request to take the received byte. Every
// input word yields exactly one output word with the tx pin level, the taken
// byte and its valid flag, the queue acknowledge and the tx busy flag.
// Both channels are valid/ready. A word is held in the input register,
// is processed by the receiver and transmitter logic, and lands in the
// output register; while the output is not stalled the block sustains one
// word per cycle. The receiver and transmitter counter and vote update lies
// between those two registers. When the output is stalled the input register
// holds its word and the input channel takes no more than that one extra
// word. Reset: receiver and transmitter idle, transmitter line level high,
// nothing pending, samples_per_bit 8, vote_threshold 4. Config writes via
// cfg_we take effect at the next clock; the user must issue them only while
// the block is idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module oversampled_uart_8n1 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ou8_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ou8_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    action,
    input  logic                          rx_line,
    input  logic [7:0]                    tx_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          tx_line,
    output logic [7:0]                    rx_byte,
    output logic                          rx_byte_valid,
    output logic                          tx_accepted,
    output logic                          tx_busy
);
    import ou8_pkg::*;

    logic [CFG_W-1:0] spb_reg, spb_next;
    logic [CFG_W-1:0] thr_reg, thr_next;

    logic       s1_valid_reg, s1_valid_next;
    action_t    s1_action_reg;
    logic       s1_line_reg;
    logic [7:0] s1_byte_reg;

    logic       out_valid_reg, out_valid_next;
    logic       tx_line_reg;
    logic [7:0] rx_byte_reg;
    logic       rx_valid_reg;
    logic       tx_acc_reg;
    logic       tx_busy_reg;

    logic       advance;
    logic       in_fire;
    logic [CFG_W-1:0] spb_eff;
    ou8_ctl_t   ctl;

    logic [7:0] take_byte;
    logic       take_valid;
    logic       tx_level;
    logic       tx_pending;
    logic       tx_acc;

    always_comb
    begin
        advance        = s1_valid_reg && (!out_valid_reg || out_ready);
        in_ready       = !s1_valid_reg || advance;
        in_fire        = in_valid && in_ready;
        s1_valid_next  = in_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        spb_eff        = clamp_spb(spb_reg);
        ctl.tick       = advance && (s1_action_reg == ACT_TICK);
        ctl.queue      = advance && (s1_action_reg == ACT_QUEUE);
        ctl.take       = advance && (s1_action_reg == ACT_TAKE);
    end

    always_comb
    begin
        spb_next = spb_reg;
        thr_next = thr_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDX_SPB: spb_next = cfg_data;
                CFG_IDX_THR: thr_next = cfg_data;
                default:     spb_next = spb_reg;
            endcase
        end
    end

    ou8_rx u_rx (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .line       (s1_line_reg),
        .spb        (spb_eff),
        .thr        (thr_reg),
        .take_byte  (take_byte),
        .take_valid (take_valid)
    );

    ou8_tx u_tx (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .spb         (spb_eff),
        .tx_byte     (s1_byte_reg),
        .level_out   (tx_level),
        .pending_out (tx_pending),
        .accepted    (tx_acc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spb_reg       <= SPB_RESET;
            thr_reg       <= THR_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            spb_reg       <= spb_next;
            thr_reg       <= thr_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_action_reg <= action_t'(action);
            s1_line_reg   <= rx_line;
            s1_byte_reg   <= tx_byte;
        end
        if (advance)
        begin
            tx_line_reg  <= tx_level;
            rx_byte_reg  <= ctl.take ? take_byte : 8'd0;
            rx_valid_reg <= ctl.take && take_valid;
            tx_acc_reg   <= tx_acc;
            tx_busy_reg  <= tx_pending;
        end
    end

    always_comb
    begin
        out_valid     = out_valid_reg;
        tx_line       = tx_line_reg;
        rx_byte       = rx_byte_reg;
        rx_byte_valid = rx_valid_reg;
        tx_accepted   = tx_acc_reg;
        tx_busy       = tx_busy_reg;
    end

endmodule

/* hw/rtl/ou8_rx.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ou8_rx
// Receiver: start detect, per-bit majority vote, stop vote, byte holding.
// ----------------------------------------------------------------------------
module ou8_rx (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ou8_pkg::ou8_ctl_t         ctl,
    input  logic                      line,
    input  logic [ou8_pkg::CFG_W-1:0] spb,
    input  logic [ou8_pkg::CFG_W-1:0] thr,
    output logic [7:0]                take_byte,
    output logic                      take_valid
);
    import ou8_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [5:0] tick_reg, tick_next;
    logic [3:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    logic [5:0] level_reg, level_next;
    logic [7:0] held_reg, held_next;
    logic       ready_reg, ready_next;

    logic [5:0] level_inc;
    logic [5:0] spb_m1;
    logic [5:0] spb_m3;
    logic [5:0] stop_len;
    logic       bit_done;
    logic [3:0] bit_inc;

    always_comb
    begin
        level_inc = (line && (level_reg != LEVEL_MAX)) ? level_reg + 6'd1 : level_reg;
        spb_m1    = spb - 6'd1;
        spb_m3    = spb - 6'd3;
        stop_len  = {spb_m1[4:0], 1'b0};
        bit_done  = (tick_reg == spb_m1);
        bit_inc   = bit_reg + 4'd1;
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        if (ctl.tick)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (!line)
                    begin
                        phase_next = PH_START;
                    end
                end
                PH_START:
                begin
                    if (tick_reg >= spb_m3)
                    begin
                        phase_next = (level_inc < thr) ? PH_DATA : PH_IDLE;
                    end
                end
                PH_DATA:
                begin
                    if ((bit_done ? bit_inc : bit_reg) >= RX_BITS)
                    begin
                        phase_next = PH_STOP;
                    end
                end
                PH_STOP:
                begin
                    if (tick_reg == stop_len)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // counters and data
    always_comb
    begin
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        level_next = level_reg;
        held_next  = held_reg;
        ready_next = ready_reg;
        if (ctl.tick)
        begin
            level_next = level_inc;
            case (phase_reg)
                PH_IDLE:
                begin
                    if (!line)
                    begin
                        level_next = '0;
                        tick_next  = '0;
                        bit_next   = '0;
                        shift_next = '0;
                        ready_next = 1'b0;
                    end
                end
                PH_START:
                begin
                    if (tick_reg >= spb_m3)
                    begin
                        tick_next  = '0;
                        level_next = '0;
                    end
                    else
                    begin
                        tick_next = tick_reg + 6'd1;
                    end
                end
                PH_DATA:
                begin
                    if (bit_done)
                    begin
                        if (level_inc > thr)
                        begin
                            shift_next[bit_reg[2:0]] = 1'b1;
                        end
                        bit_next   = bit_inc;
                        tick_next  = '0;
                        level_next = '0;
                    end
                    else
                    begin
                        tick_next = tick_reg + 6'd1;
                    end
                end
                PH_STOP:
                begin
                    if (tick_reg == stop_len)
                    begin
                        if (level_inc > thr)
                        begin
                            held_next  = shift_reg;
                            ready_next = 1'b1;
                        end
                    end
                    else
                    begin
                        tick_next = tick_reg + 6'd1;
                    end
                end
                default:
                begin
                    tick_next = tick_reg;
                end
            endcase
        end
        if (ctl.take)
        begin
            ready_next = 1'b0;
        end
    end

    always_comb
    begin
        take_valid = ready_reg;
        take_byte  = ready_reg ? held_reg : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            level_reg <= '0;
            held_reg  <= '0;
            ready_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            level_reg <= level_next;
            held_reg  <= held_next;
            ready_reg <= ready_next;
        end
    end

endmodule

/* hw/rtl/ou8_tx.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ou8_tx
// Transmitter: one pending byte, then start, 8 data bits LSB first, long stop.
// ----------------------------------------------------------------------------
module ou8_tx (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ou8_pkg::ou8_ctl_t         ctl,
    input  logic [ou8_pkg::CFG_W-1:0] spb,
    input  logic [7:0]                tx_byte,
    output logic                      level_out,
    output logic                      pending_out,
    output logic                      accepted
);
    import ou8_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [6:0] tick_reg, tick_next;
    logic [2:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] pbyte_reg, pbyte_next;
    logic       pending_reg, pending_next;
    logic       level_reg, level_next;

    logic [6:0] spb_m1;
    logic [6:0] stop_len;
    logic       in_bit;

    always_comb
    begin
        spb_m1   = {1'b0, spb} - 7'd1;
        stop_len = {spb_m1[4:0], 2'b00};
        in_bit   = (tick_reg < spb_m1);
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        if (ctl.tick)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (pending_reg)
                    begin
                        phase_next = PH_START;
                    end
                end
                PH_START:
                begin
                    if (!in_bit)
                    begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (!in_bit && (bit_reg >= TX_LAST_BIT))
                    begin
                        phase_next = PH_STOP;
                    end
                end
                PH_STOP:
                begin
                    if (tick_reg >= stop_len)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // counters, line level and pending slot
    always_comb
    begin
        tick_next    = tick_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        pbyte_next   = pbyte_reg;
        pending_next = pending_reg;
        level_next   = level_reg;
        accepted     = 1'b0;
        if (ctl.tick)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (pending_reg)
                    begin
                        tick_next    = '0;
                        shift_next   = pbyte_reg;
                        pending_next = 1'b0;
                    end
                    else
                    begin
                        level_next = 1'b1;
                    end
                end
                PH_START:
                begin
                    if (in_bit)
                    begin
                        level_next = 1'b0;
                        tick_next  = tick_reg + 7'd1;
                    end
                    else
                    begin
                        tick_next = '0;
                        bit_next  = '0;
                    end
                end
                PH_DATA:
                begin
                    if (in_bit)
                    begin
                        level_next = shift_reg[bit_reg];
                        tick_next  = tick_reg + 7'd1;
                    end
                    else if (bit_reg < TX_LAST_BIT)
                    begin
                        tick_next = '0;
                        bit_next  = bit_reg + 3'd1;
                    end
                end
                PH_STOP:
                begin
                    // tick counter is left alone, so stop runs from spb-1 upward
                    if (tick_reg < stop_len)
                    begin
                        level_next = 1'b1;
                        tick_next  = tick_reg + 7'd1;
                    end
                end
                default:
                begin
                    level_next = 1'b1;
                end
            endcase
        end
        if (ctl.queue && !pending_reg)
        begin
            pbyte_next   = tx_byte;
            pending_next = 1'b1;
            accepted     = 1'b1;
        end
    end

    always_comb
    begin
        level_out   = level_next;
        pending_out = pending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            bit_reg     <= '0;
            shift_reg   <= '0;
            pbyte_reg   <= '0;
            pending_reg <= 1'b0;
            level_reg   <= 1'b1;
        end
        else
        begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            pbyte_reg   <= pbyte_next;
            pending_reg <= pending_next;
            level_reg   <= level_next;
        end
    end

endmodule

/* hw/rtl/ou8_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ou8_checker
// Port-level checks for the oversampled UART, bound to the top level.
// ----------------------------------------------------------------------------
module ou8_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] rx_byte,
    input logic       rx_byte_valid,
    input logic       tx_accepted,
    input logic       tx_busy
);

    // a stalled output word stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    // no byte returned means the byte field reads zero
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !rx_byte_valid |-> rx_byte == 8'd0)
        else $error("rx_byte nonzero without rx_byte_valid");

    // one word is either a take or a queue, never both
    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(rx_byte_valid && tx_accepted))
        else $error("take and queue reported in one word");

    // an accepted queue request leaves a byte pending
    a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tx_accepted |-> tx_busy)
        else $error("tx_accepted without tx_busy");

endmodule

bind oversampled_uart_8n1 ou8_checker u_ou8_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .rx_byte       (rx_byte),
    .rx_byte_valid (rx_byte_valid),
    .tx_accepted   (tx_accepted),
    .tx_busy       (tx_busy)
);
